// ===== hdl/skj_pkg.sv =====
`default_nettype none
package skj_pkg;

  localparam int unsigned NUM_STAGES = 64;

  localparam logic KEY_UPPER_IDX = 1'b0;
  localparam logic KEY_LOWER_IDX = 1'b1;

  localparam logic KIND_ENCRYPT = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [63:0] blk;
    logic [15:0] g;
  } stage_t;

  localparam logic [7:0] FTAB [256] = '{
    8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
    8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
    8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
    8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
    8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
    8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
    8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
    8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
    8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
    8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
    8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
    8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
    8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
    8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
    8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
    8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
  };

  // key byte position (4*rm1 + j) mod 10, by reciprocal multiply
  function automatic logic [3:0] key_pos(input logic [4:0] rm1, input logic [1:0] j);
    logic [6:0]  n;
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  rem;
    n    = {rm1, 2'b00} + 7'(j);
    prod = 15'(n) * 15'd205;
    q    = prod[14:11];
    rem  = n - 7'(q) * 7'd10;
    return rem[3:0];
  endfunction

  function automatic logic [7:0] key_byte(input logic [79:0] key, input logic [3:0] pos);
    logic [7:0] b;
    unique case (pos)
      4'd0:    b = key[79:72];
      4'd1:    b = key[71:64];
      4'd2:    b = key[63:56];
      4'd3:    b = key[55:48];
      4'd4:    b = key[47:40];
      4'd5:    b = key[39:32];
      4'd6:    b = key[31:24];
      4'd7:    b = key[23:16];
      4'd8:    b = key[15:8];
      4'd9:    b = key[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/skj_half_round.sv =====
`default_nettype none
module skj_half_round (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic [5:0]      idx,
  input  wire logic [79:0]     key,
  input  wire logic            in_valid,
  input  wire skj_pkg::stage_t in_data,
  output logic                 out_valid,
  output skj_pkg::stage_t      out_data
);

  logic            valid;
  skj_pkg::stage_t data;
  skj_pkg::stage_t data_next;

  logic [15:0] w0, w1, w2, w3;
  logic [4:0]  p;
  logic        half;
  logic        enc;
  logic [4:0]  rm1;
  logic [15:0] rnd;
  logic [1:0]  ja, jb;
  logic [7:0]  ka, kb;
  logic [15:0] src, g;
  logic [7:0]  h1, l1, h2, l2;

  always_comb begin
    w0   = in_data.blk[63:48];
    w1   = in_data.blk[47:32];
    w2   = in_data.blk[31:16];
    w3   = in_data.blk[15:0];
    p    = idx[5:1];
    half = idx[0];
    enc  = (in_data.kind == skj_pkg::KIND_ENCRYPT);
    rm1  = enc ? p : ~p;
    rnd  = 16'(rm1) + 16'd1;
    if (enc) begin
      ja = half ? 2'd2 : 2'd0;
      jb = ja + 2'd1;
    end else begin
      ja = half ? 2'd1 : 2'd3;
      jb = ja - 2'd1;
    end
    ka  = skj_pkg::key_byte(key, skj_pkg::key_pos(rm1, ja));
    kb  = skj_pkg::key_byte(key, skj_pkg::key_pos(rm1, jb));
    src = half ? in_data.g : (enc ? w0 : w1);
    if (enc) begin
      h1 = src[15:8] ^ skj_pkg::FTAB[src[7:0] ^ ka];
      l1 = src[7:0];
      l2 = l1 ^ skj_pkg::FTAB[h1 ^ kb];
      h2 = h1;
    end else begin
      l1 = src[7:0] ^ skj_pkg::FTAB[src[15:8] ^ ka];
      h1 = src[15:8];
      h2 = h1 ^ skj_pkg::FTAB[l1 ^ kb];
      l2 = l1;
    end
    g = {h2, l2};

    data_next      = in_data;
    data_next.g    = g;
    if (half) begin
      if (enc) begin
        if (!rm1[3]) begin
          data_next.blk = {g ^ w3 ^ rnd, g, w1, w2};
        end else begin
          data_next.blk = {w3, g, w0 ^ w1 ^ rnd, w2};
        end
      end else begin
        if (!rm1[3]) begin
          data_next.blk = {g, w2, w3, w0 ^ w1 ^ rnd};
        end else begin
          data_next.blk = {g, g ^ w2 ^ rnd, w3, w0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule
`default_nettype wire

// ===== hdl/skj_out_buf.sv =====
`default_nettype none
module skj_out_buf (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic [63:0] push_data,
  output logic             space,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_data
);

  logic [63:0] mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop       = (count != 2'd0) && out_ready;
  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/skipjack_block_cipher.sv =====
`default_nettype none
// Path: each block passes through the 64 half-round stage registers, then the output buffer.
// Throughput: one block per cycle while the output buffer has space; 64 half-round stages, two F-table steps each.
// A two-entry output buffer holds results; in_ready drops only when it is full.
// Reset: rst (synchronous, active high) clears stage valid bits, buffer and key.
module skipjack_block_cipher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [63:0] block_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      block_out,
  input  wire logic        cfg_en,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [15:0] key_upper;
  logic [63:0] key_lower;
  logic [79:0] key;

  logic            pipe_valid [skj_pkg::NUM_STAGES + 1];
  skj_pkg::stage_t pipe_data  [skj_pkg::NUM_STAGES + 1];
  logic            en;
  logic            space;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        skj_pkg::KEY_UPPER_IDX: key_upper <= cfg_data[15:0];
        skj_pkg::KEY_LOWER_IDX: key_lower <= cfg_data;
        default:                key_lower <= key_lower;
      endcase
    end
  end

  assign key      = {key_upper, key_lower};
  assign en       = space;
  assign in_ready = en;

  assign pipe_valid[0]     = in_valid;
  assign pipe_data[0].kind = kind;
  assign pipe_data[0].blk  = block_in;
  assign pipe_data[0].g    = 16'h0000;

  for (genvar i = 0; i < skj_pkg::NUM_STAGES; i++) begin : g_stage
    skj_half_round u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .idx       (6'(i)),
      .key       (key),
      .in_valid  (pipe_valid[i]),
      .in_data   (pipe_data[i]),
      .out_valid (pipe_valid[i+1]),
      .out_data  (pipe_data[i+1])
    );
  end

  skj_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (en && pipe_valid[skj_pkg::NUM_STAGES]),
    .push_data (pipe_data[skj_pkg::NUM_STAGES].blk),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (block_out)
  );

endmodule
`default_nettype wire

// ===== hdl/skj_checker.sv =====
`default_nettype none
module skj_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] block_out
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(block_out))
    else $error("stalled result beat dropped or changed");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stall without output backpressure");

endmodule

bind skipjack_block_cipher skj_checker u_skj_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .block_out (block_out)
);
`default_nettype wire
